/* hdl/cfur_pkg.sv */
// Package for the CAN firmware upgrade receiver: types, codes and CRC helper.
// No dependencies.
package cfur_pkg;

   localparam int PageBytes = 256;
   localparam int PosW = $clog2(PageBytes) + 1;

   localparam logic [7:0] CmdStart = 8'hF1;
   localparam logic [7:0] CmdData  = 8'hF2;
   localparam logic [7:0] CmdEnd   = 8'hF3;

   localparam logic [1:0] KindReply = 2'd0;
   localparam logic [1:0] KindByte  = 2'd1;
   localparam logic [1:0] KindPage  = 2'd2;
   localparam logic [1:0] KindErase = 2'd3;

   localparam logic [7:0] StEraseOk    = 8'd0;
   localparam logic [7:0] StPassFail   = 8'd1;
   localparam logic [7:0] StNoMemory   = 8'd2;
   localparam logic [7:0] StEraseStart = 8'd3;
   localparam logic [7:0] ResSuccess   = 8'd0;
   localparam logic [7:0] ResCrcFail   = 8'd1;

   localparam logic [1:0] RegDeviceId = 2'd0;
   localparam logic [1:0] RegMaxImage = 2'd1;
   localparam logic [1:0] RegMaxFrame = 2'd2;
   localparam logic [1:0] RegAppStart = 2'd3;

   localparam logic [31:0] CrcPoly = 32'h04C11DB7;

   typedef enum logic [1:0] {
      PH_IDLE, PH_READY, PH_RECEIVING, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      OP_START, OP_DATA, OP_END
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_START, BK_DATA, BK_END
   } back_state_type;

   // Classified frame handed from front to back
   typedef struct packed {
      op_type      op;
      logic [3:0]  len;
      logic [63:0] bytes;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  reply_length;
      logic [63:0] reply_bytes;
      logic [7:0]  buffer_offset;
      logic [7:0]  buffer_byte;
      logic [31:0] page_address;
      logic [8:0]  page_fill;
      logic        last;
   } result_type;

   // One 8-bit step of the MSB-first CRC: each bit shifts then folds the data bit
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
      logic [31:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
         if (d[i]) c = c ^ CrcPoly;
      end
      return c;
   endfunction

endpackage

/* hdl/cfur_if.sv */
// Handshake channel interfaces: frame, result and register write.
// No dependencies.
interface cfur_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  frame_length;
   logic [63:0] frame_bytes;
   modport source (output valid, frame_length, frame_bytes, input ready);
   modport sink (input valid, frame_length, frame_bytes, output ready);
endinterface

interface cfur_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  reply_length;
   logic [63:0] reply_bytes;
   logic [7:0]  buffer_offset;
   logic [7:0]  buffer_byte;
   logic [31:0] page_address;
   logic [8:0]  page_fill;
   logic        last;
   modport source (output valid, kind, reply_length, reply_bytes, buffer_offset,
                   buffer_byte, page_address, page_fill, last, input ready);
   modport sink (input valid, kind, reply_length, reply_bytes, buffer_offset,
                 buffer_byte, page_address, page_fill, last, output ready);
endinterface

interface cfur_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/cfur_front.sv */
// Front end: accepts frames, drops empty/short/unknown ones, queues commands.
// Depends on cfur_pkg.
module cfur_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_frame_length,
   input  logic [63:0]         req_frame_bytes,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output cfur_pkg::cmd_type   cmd
);
   import cfur_pkg::*;

   localparam int Depth = 2;

   cmd_type    q_ff [Depth];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [3:0] len;
   logic       keep;
   cmd_type    cls;
   logic       push, pop;

   // Classify: clamp length, keep only well-formed known commands
   always_comb begin
      len  = (req_frame_length > 4'd8) ? 4'd8 : req_frame_length;
      keep = 1'b0;
      cls.len   = len;
      cls.bytes = req_frame_bytes;
      cls.op    = OP_START;
      case (req_frame_bytes[7:0])
         CmdStart: begin keep = (len >= 4'd7); cls.op = OP_START; end
         CmdData:  begin keep = (len >= 4'd5); cls.op = OP_DATA; end
         CmdEnd:   begin keep = (len >= 4'd5); cls.op = OP_END; end
         default:  keep = 1'b0;
      endcase
   end

   assign req_ready = (cnt_ff != 2'(Depth));
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   // Queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cls;
   end

endmodule

/* hdl/cfur_back.sv */
// Back end: executes start/data/end commands, one result beat per cycle while
// res_ready does not stall, with a one-entry output register. Depends on cfur_pkg.
module cfur_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  cfur_pkg::cmd_type   cmd,
   input  logic [15:0]         device_id,
   input  logic [23:0]         max_image_size,
   input  logic [7:0]          max_frame_length,
   input  logic [31:0]         app_start_address,
   output logic                res_valid,
   input  logic                res_ready,
   output cfur_pkg::result_type res
);
   import cfur_pkg::*;

   phase_type      phase_ff, phase_in;
   back_state_type st_ff, st_in;
   logic [2:0]     step_ff, step_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [31:0]    paddr_ff, paddr_in;
   logic [31:0]    crc_ff, crc_in;
   logic [23:0]    wasm_ff, wasm_in;
   logic [1:0]     wcnt_ff, wcnt_in;
   logic [23:0]    eaddr_ff, eaddr_in;
   logic [23:0]    total_ff, total_in;
   logic [24:0]    rcvd_ff, rcvd_in;
   logic           pgpend_ff, pgpend_in;
   cmd_type        c_ff, c_in;
   logic           ov_ff, ov_in;
   result_type     o_ff, o_in;

   logic        slot;
   logic        emit;
   result_type  r;
   logic [15:0] good;
   logic [63:0] base;
   logic [2:0]  nbytes;
   logic [7:0]  v;
   logic [23:0] fa;
   logic [31:0] host;
   logic        fail;
   logic [PosW-1:0] pos_inc;

   assign slot      = !ov_ff || res_ready;
   assign res_valid = ov_ff;
   assign res       = o_ff;
   assign cmd_ready = (st_ff == BK_IDLE);

   always_comb begin
      good   = 16'(device_id * 16'h1234) ^ 16'hABCD;
      base   = {24'd0, max_frame_length, good, 8'd0, CmdStart};
      nbytes = 3'(c_ff.len - 4'd4);
      v      = c_ff.bytes[8 * (4 + step_ff) +: 8];
      fa     = c_ff.bytes[31:8];
      host   = c_ff.bytes[39:8];
      fail   = (c_ff.bytes[47:32] != good) || (fa > max_image_size);
      pos_inc = pos_ff + 1'b1;
   end

   // Next state: sequencer over the result beats of one command
   always_comb begin
      st_in   = st_ff;
      step_in = step_ff;
      c_in    = c_ff;
      if (st_ff == BK_IDLE) begin
         if (cmd_valid) begin
            c_in    = cmd;
            step_in = 3'd0;
            case (cmd.op)
               OP_START: st_in = BK_START;
               OP_DATA:  st_in = (phase_ff == PH_READY || phase_ff == PH_RECEIVING)
                                 ? BK_DATA : BK_IDLE;
               OP_END:   st_in = (phase_ff == PH_RECEIVING) ? BK_END : BK_IDLE;
               default:  st_in = BK_IDLE;
            endcase
            if (phase_ff == PH_DONE) st_in = BK_IDLE;
         end
      end else if (slot) begin
         case (st_ff)
            BK_START: begin
               if (fail || step_ff == 3'd2) st_in = BK_IDLE;
               else step_in = step_ff + 3'd1;
            end
            BK_DATA: begin
               if (pgpend_ff) begin
               end else if (step_ff == nbytes) st_in = BK_IDLE;
               else step_in = step_ff + 3'd1;
            end
            BK_END: begin
               if (step_ff == 3'd1 || pos_ff == '0) st_in = BK_IDLE;
               else step_in = step_ff + 3'd1;
            end
            default: st_in = BK_IDLE;
         endcase
      end
   end

   // Outputs and datapath updates per beat
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      paddr_in  = paddr_ff;
      crc_in    = crc_ff;
      wasm_in   = wasm_ff;
      wcnt_in   = wcnt_ff;
      eaddr_in  = eaddr_ff;
      total_in  = total_ff;
      rcvd_in   = rcvd_ff;
      pgpend_in = pgpend_ff;
      r         = '0;
      emit      = 1'b0;
      if (st_ff != BK_IDLE && slot) begin
         emit = 1'b1;
         case (st_ff)
            BK_START: begin
               r.kind = KindReply;
               r.reply_length = 4'd5;
               if (c_ff.bytes[47:32] != good) begin
                  r.reply_bytes = base | {48'd0, StPassFail, 8'd0};
                  r.last = 1'b1;
               end else if (fa > max_image_size) begin
                  r.reply_bytes = base | {48'd0, StNoMemory, 8'd0};
                  r.last = 1'b1;
               end else if (step_ff == 3'd0) begin
                  r.reply_bytes = base | {48'd0, StEraseStart, 8'd0};
               end else if (step_ff == 3'd1) begin
                  r = '0;
                  r.kind = KindErase;
                  r.page_address = app_start_address;
               end else begin
                  r.reply_bytes = base | {48'd0, StEraseOk, 8'd0};
                  r.last = 1'b1;
                  phase_in = PH_READY;
                  total_in = fa;
                  rcvd_in  = '0;
                  eaddr_in = '0;
                  pos_in   = '0;
                  paddr_in = app_start_address;
                  crc_in   = 32'hFFFFFFFF;
                  wasm_in  = '0;
                  wcnt_in  = '0;
               end
            end
            BK_DATA: begin
               phase_in = PH_RECEIVING;
               if (pgpend_ff) begin
                  r.kind = KindPage;
                  r.page_address = paddr_ff;
                  r.page_fill = 9'(PageBytes);
                  paddr_in  = paddr_ff + 32'(PageBytes);
                  pos_in    = '0;
                  pgpend_in = 1'b0;
               end else if (step_ff == nbytes) begin
                  r.kind = KindReply;
                  r.reply_length = 4'd4;
                  eaddr_in = fa + 24'(nbytes);
                  r.reply_bytes = {32'd0, eaddr_in, CmdData};
                  rcvd_in = rcvd_ff + 25'(nbytes);
                  r.last = 1'b1;
               end else begin
                  r.kind = KindByte;
                  r.buffer_offset = pos_ff[7:0];
                  r.buffer_byte = v;
                  pos_in = pos_inc;
                  pgpend_in = (pos_inc >= PosW'(PageBytes));
                  if (wcnt_ff == 2'd3) begin
                     crc_in  = crc_byte(crc_byte(crc_byte(crc_byte(crc_ff,
                               v), wasm_ff[23:16]), wasm_ff[15:8]), wasm_ff[7:0]);
                     wasm_in = '0;
                     wcnt_in = '0;
                  end else begin
                     wasm_in = wasm_ff | (24'(v) << (8 * wcnt_ff));
                     wcnt_in = wcnt_ff + 2'd1;
                  end
               end
            end
            BK_END: begin
               if (step_ff == 3'd0 && pos_ff != '0) begin
                  r.kind = KindPage;
                  r.page_address = paddr_ff;
                  r.page_fill = 9'(pos_ff);
                  paddr_in = paddr_ff + 32'(PageBytes);
                  pos_in   = '0;
               end else begin
                  r.kind = KindReply;
                  r.reply_length = 4'd6;
                  r.reply_bytes = {16'd0, crc_ff,
                                   (host == crc_ff) ? ResSuccess : ResCrcFail, CmdEnd};
                  r.last = 1'b1;
                  phase_in = (host == crc_ff) ? PH_DONE : PH_IDLE;
               end
            end
            default: emit = 1'b0;
         endcase
      end
      ov_in = emit ? 1'b1 : (res_ready ? 1'b0 : ov_ff);
      o_in  = emit ? r : o_ff;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         st_ff     <= BK_IDLE;
         step_ff   <= '0;
         pos_ff    <= '0;
         paddr_ff  <= '0;
         crc_ff    <= 32'hFFFFFFFF;
         wasm_ff   <= '0;
         wcnt_ff   <= '0;
         eaddr_ff  <= '0;
         total_ff  <= '0;
         rcvd_ff   <= '0;
         pgpend_ff <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         st_ff     <= st_in;
         step_ff   <= step_in;
         pos_ff    <= pos_in;
         paddr_ff  <= paddr_in;
         crc_ff    <= crc_in;
         wasm_ff   <= wasm_in;
         wcnt_ff   <= wcnt_in;
         eaddr_ff  <= eaddr_in;
         total_ff  <= total_in;
         rcvd_ff   <= rcvd_in;
         pgpend_ff <= pgpend_in;
         ov_ff     <= ov_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      c_ff <= c_in;
      o_ff <= o_in;
   end

endmodule

/* hdl/can_firmware_upgrade_receiver.sv */
// A frame passes the command queue, the back command register and the output register
// before its first result beat; one result beat per cycle unless rsp.ready stalls.
// A frame yields up to five result beats plus one per page program. The back sequencer
// takes commands only when idle; the front's two-entry queue takes frames meanwhile.
// Reset (synchronous): phase idle, CRC all ones, registers to their defaults.
// Top level of the CAN firmware upgrade receiver. Depends on cfur_pkg, cfur_if,
// cfur_front, cfur_back.
module can_firmware_upgrade_receiver (
   input  logic clock,
   input  logic reset,
   cfur_req_if.sink   req,
   cfur_rsp_if.source rsp,
   cfur_csr_if.sink   csr
);
   import cfur_pkg::*;

   logic        cmd_valid, cmd_ready, res_valid;
   cmd_type     cmd;
   result_type  res;
   logic [15:0] dev_ff;
   logic [23:0] maxim_ff;
   logic [7:0]  maxfr_ff;
   logic [31:0] app_ff;

   assign csr.ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff   <= '0;
         maxim_ff <= 24'hFFFFFF;
         maxfr_ff <= 8'd8;
         app_ff   <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            RegDeviceId: dev_ff   <= csr.data[15:0];
            RegMaxImage: maxim_ff <= csr.data[23:0];
            RegMaxFrame: maxfr_ff <= csr.data[7:0];
            RegAppStart: app_ff   <= csr.data;
            default: ;
         endcase
      end
   end

   cfur_front u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_frame_length(req.frame_length), .req_frame_bytes(req.frame_bytes),
      .cmd_valid, .cmd_ready, .cmd
   );

   cfur_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .device_id(dev_ff), .max_image_size(maxim_ff),
      .max_frame_length(maxfr_ff), .app_start_address(app_ff),
      .res_valid, .res_ready(rsp.ready), .res
   );

   assign rsp.valid         = res_valid;
   assign rsp.kind          = res.kind;
   assign rsp.reply_length  = res.reply_length;
   assign rsp.reply_bytes   = res.reply_bytes;
   assign rsp.buffer_offset = res.buffer_offset;
   assign rsp.buffer_byte   = res.buffer_byte;
   assign rsp.page_address  = res.page_address;
   assign rsp.page_fill     = res.page_fill;
   assign rsp.last          = res.last;

endmodule

/* hdl/cfur_checker.sv */
// Port-level checker for the upgrade receiver, bound to the top level.
// Depends on cfur_pkg.
module cfur_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [3:0]  rsp_reply_length,
   input logic [8:0]  rsp_page_fill,
   input logic        rsp_last
);
   import cfur_pkg::*;

   // A stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result beat dropped while stalled");

   // Byte writes are never the final beat of a frame
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindByte |-> !rsp_last)
      else $error("byte write marked last");

   // Program page carries a nonzero fill
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindPage |-> rsp_page_fill != 9'd0)
      else $error("empty page program");

   // Replies have length 4 to 6
   a_rlen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindReply |->
         (rsp_reply_length == 4'd4 || rsp_reply_length == 4'd5 ||
          rsp_reply_length == 4'd6))
      else $error("bad reply length");

endmodule

bind can_firmware_upgrade_receiver cfur_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.kind),
   .rsp_reply_length(rsp.reply_length), .rsp_page_fill(rsp.page_fill),
   .rsp_last(rsp.last)
);
